>>> rtl/ftkp_pkg.sv
package ftkp_pkg;

	localparam int MAX_TRACKS = 256;
	localparam int WINDOW     = 128;
	localparam int ID_BITS    = 20;
	localparam int COORD_BITS = 16;

	localparam int SLOT_BITS  = $clog2(MAX_TRACKS);
	localparam int IDX_BITS   = $clog2(WINDOW);
	localparam int LEN_BITS   = IDX_BITS + 1;
	localparam int FRAME_BITS = 7;
	localparam int CNT_BITS   = 9;
	localparam int PT_ADDR_BITS = SLOT_BITS + IDX_BITS;

	// |dx| needs one bit more than a coordinate; dx^2 + dy^2 one more again
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int RAD_BITS  = 2 * DIFF_BITS + 1;
	localparam int ROOT_BITS = (RAD_BITS + 1) / 2;
	localparam int SUM_BITS  = ROOT_BITS + SLOT_BITS + 1;
	localparam int MINP_BITS = 16;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CNT_BITS-1:0]  RST_MIN_TRACKED  = CNT_BITS'(20);
	localparam logic [MINP_BITS-1:0] RST_PLX_THR      = MINP_BITS'(4096);
	localparam logic [CNT_BITS-1:0]  CNT_SAT          = '1;
	localparam logic [FRAME_BITS-1:0] FRAME_GAP       = FRAME_BITS'(2);

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_DECIDE = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MIN_TRACKED  = 2'd0,
		CFG_PLX_THR      = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [ID_BITS-1:0]    ident;
		logic [FRAME_BITS-1:0] start;
		logic [LEN_BITS-1:0]   len;
	} meta_t;

	typedef struct packed {
		logic load;
		logic slot_clr;
		logic clear;
		logic scan;
		logic commit;
		logic direct;
		logic dec_init;
		logic chk;
		logic next;
		logic pt_sel;
		logic p0_lat;
		logic diff;
		logic mul;
		logic sqrt_step;
		logic acc;
		logic prod;
		logic out_load;
	} ftkp_cmd_t;

	typedef struct packed {
		action_t act;
		logic    scan_last;
		logic    direct;
		logic    qual;
		logic    slot_last;
		logic    sqrt_last;
		logic    out_busy;
	} ftkp_stat_t;

endpackage

>>> rtl/ftkp_ifs.sv
interface ftkp_item_if;
	import ftkp_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   action;
	logic [FRAME_BITS-1:0]        frame_index;
	logic [ID_BITS-1:0]           feat_tag;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	modport source (output valid, action, frame_index, feat_tag, point_x, point_y,
		input ready);
	modport sink (input valid, action, frame_index, feat_tag, point_x, point_y,
		output ready);
endinterface

interface ftkp_res_if;
	import ftkp_pkg::*;
	logic                valid;
	logic                ready;
	logic                is_keyframe;
	logic [CNT_BITS-1:0] tracked_count;
	logic [CNT_BITS-1:0] parallax_count;
	logic                dropped_flag;
	modport source (output valid, is_keyframe, tracked_count, parallax_count, dropped_flag,
		input ready);
	modport sink (input valid, is_keyframe, tracked_count, parallax_count, dropped_flag,
		output ready);
endinterface

>>> rtl/ftkp_ctrl.sv
module ftkp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ftkp_pkg::ftkp_stat_t stat,
	output ftkp_pkg::ftkp_cmd_t  cmd
);
	import ftkp_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE     = 15'h0001,
		S_DISP     = 15'h0002,
		S_ADD_SCAN = 15'h0004,
		S_ADD_TAIL = 15'h0008,
		S_ADD_WR   = 15'h0010,
		S_DEC_RD   = 15'h0020,
		S_DEC_CHK  = 15'h0040,
		S_DEC_PA   = 15'h0080,
		S_DEC_PB   = 15'h0100,
		S_DEC_PC   = 15'h0200,
		S_DEC_MUL  = 15'h0400,
		S_DEC_SQRT = 15'h0800,
		S_DEC_ACC  = 15'h1000,
		S_DEC_PROD = 15'h2000,
		S_DEC_FIN  = 15'h4000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				cmd.slot_clr = 1'b1;
				unique case (stat.act)
					ACT_ADD:    state_d = S_ADD_SCAN;
					ACT_DECIDE: begin
						if (stat.direct) begin
							cmd.direct = 1'b1;
							state_d    = S_DEC_FIN;
						end else begin
							cmd.dec_init = 1'b1;
							state_d      = S_DEC_RD;
						end
					end
					ACT_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ADD_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last)
					state_d = S_ADD_TAIL;
			end
			S_ADD_TAIL: state_d = S_ADD_WR;
			S_ADD_WR: begin
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			S_DEC_RD: state_d = S_DEC_CHK;
			S_DEC_CHK: begin
				cmd.chk = 1'b1;
				if (stat.qual) begin
					state_d = S_DEC_PA;
				end else if (stat.slot_last) begin
					state_d = S_DEC_PROD;
				end else begin
					cmd.next = 1'b1;
					state_d  = S_DEC_RD;
				end
			end
			S_DEC_PA: state_d = S_DEC_PB;
			S_DEC_PB: begin
				cmd.pt_sel = 1'b1;
				cmd.p0_lat = 1'b1;
				state_d    = S_DEC_PC;
			end
			S_DEC_PC: begin
				cmd.diff = 1'b1;
				state_d  = S_DEC_MUL;
			end
			S_DEC_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DEC_SQRT;
			end
			S_DEC_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (stat.sqrt_last)
					state_d = S_DEC_ACC;
			end
			S_DEC_ACC: begin
				cmd.acc = 1'b1;
				if (stat.slot_last) begin
					state_d = S_DEC_PROD;
				end else begin
					cmd.next = 1'b1;
					state_d  = S_DEC_RD;
				end
			end
			S_DEC_PROD: begin
				cmd.prod = 1'b1;
				state_d  = S_DEC_FIN;
			end
			S_DEC_FIN: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

>>> rtl/ftkp_dp.sv
module ftkp_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ftkp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [ftkp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic [1:0]                           in_action,
	input  logic [ftkp_pkg::FRAME_BITS-1:0]      in_frame,
	input  logic [ftkp_pkg::ID_BITS-1:0]         in_id,
	input  logic signed [ftkp_pkg::COORD_BITS-1:0] in_x,
	input  logic signed [ftkp_pkg::COORD_BITS-1:0] in_y,
	input  ftkp_pkg::ftkp_cmd_t                  cmd,
	output ftkp_pkg::ftkp_stat_t                 stat,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 out_key,
	output logic [ftkp_pkg::CNT_BITS-1:0]        out_tracked,
	output logic [ftkp_pkg::CNT_BITS-1:0]        out_count,
	output logic                                 out_dropped
);
	import ftkp_pkg::*;

	logic [CNT_BITS-1:0]  min_tracked_q;
	logic [MINP_BITS-1:0] min_par_q;

	action_t                act_q;
	logic [FRAME_BITS-1:0]  frame_q;
	logic [ID_BITS-1:0]     id_q;
	logic [2*COORD_BITS-1:0] pt_q;

	logic [MAX_TRACKS-1:0] valid_q;
	meta_t meta_mem [MAX_TRACKS];
	meta_t meta_rd_q;
	logic [2*COORD_BITS-1:0] pts_mem [MAX_TRACKS*WINDOW];
	logic [2*COORD_BITS-1:0] pts_rd_q;

	logic [SLOT_BITS-1:0] slot_q, slot_s1;
	logic                 eval_s1;
	logic                 hit_q, free_q;
	logic [SLOT_BITS-1:0] hit_slot_q, free_slot_q;
	meta_t                hit_meta_q;

	logic [CNT_BITS-1:0] tracked_q;
	logic                dropped_q;

	logic [IDX_BITS-1:0]     idx_q;
	logic [2*COORD_BITS-1:0] p0_q;
	logic [DIFF_BITS-1:0]    dx_q, dy_q;
	logic [RAD_BITS-1:0]     rad_q, res_q, bit_q;
	logic [SUM_BITS-1:0]     sum_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [SUM_BITS-1:0]     prod_q;
	logic                    force_q;
	logic                    out_valid_q;

	// write port
	logic                    meta_we, pts_we;
	logic [SLOT_BITS-1:0]    wr_slot;
	meta_t                   meta_wd;
	logic [PT_ADDR_BITS-1:0] pts_wa, pts_ra;

	logic [IDX_BITS-1:0]     idx_d;
	logic [FRAME_BITS:0]     start_gap, track_end;
	logic signed [COORD_BITS:0] ddx, ddy;
	logic [RAD_BITS-1:0]     trial;

	always_comb begin
		meta_we = 1'b0;
		pts_we  = 1'b0;
		wr_slot = hit_slot_q;
		meta_wd = hit_meta_q;
		pts_wa  = {hit_slot_q, hit_meta_q.len[IDX_BITS-1:0]};
		if (cmd.commit) begin
			if (hit_q) begin
				if (hit_meta_q.len < LEN_BITS'(WINDOW)) begin
					meta_we     = 1'b1;
					pts_we      = 1'b1;
					meta_wd.len = hit_meta_q.len + LEN_BITS'(1);
				end
			end else if (free_q) begin
				meta_we = 1'b1;
				pts_we  = 1'b1;
				wr_slot = free_slot_q;
				meta_wd = '{ident: id_q, start: frame_q, len: LEN_BITS'(1)};
				pts_wa  = {free_slot_q, {IDX_BITS{1'b0}}};
			end
		end
	end

	assign pts_ra = {slot_q, idx_q + IDX_BITS'(cmd.pt_sel)};

	always_ff @(posedge clk) begin
		if (meta_we)
			meta_mem[wr_slot] <= meta_wd;
		meta_rd_q <= meta_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (pts_we)
			pts_mem[pts_wa] <= pt_q;
		pts_rd_q <= pts_mem[pts_ra];
	end

	// qualification of the track under the slot counter
	assign start_gap = {1'b0, meta_rd_q.start} + {1'b0, FRAME_GAP};
	assign track_end = {1'b0, meta_rd_q.start} + {1'b0, meta_rd_q.len[FRAME_BITS-1:0]}
		+ {meta_rd_q.len[LEN_BITS-1], {FRAME_BITS{1'b0}}};
	assign idx_d = IDX_BITS'(frame_q - FRAME_GAP - meta_rd_q.start);

	assign ddx = $signed({p0_q[2*COORD_BITS-1], p0_q[2*COORD_BITS-1:COORD_BITS]})
		- $signed({pts_rd_q[2*COORD_BITS-1], pts_rd_q[2*COORD_BITS-1:COORD_BITS]});
	assign ddy = $signed({p0_q[COORD_BITS-1], p0_q[COORD_BITS-1:0]})
		- $signed({pts_rd_q[COORD_BITS-1], pts_rd_q[COORD_BITS-1:0]});

	assign trial = res_q + bit_q;

	assign stat.act       = act_q;
	assign stat.scan_last = (slot_q == '1);
	assign stat.direct    = (frame_q < FRAME_GAP) || (tracked_q < min_tracked_q);
	assign stat.qual      = valid_q[slot_q] && (start_gap <= {1'b0, frame_q})
		&& (track_end >= {1'b0, frame_q});
	assign stat.slot_last = (slot_q == '1);
	assign stat.sqrt_last = bit_q[0];
	assign stat.out_busy  = out_valid_q && !out_ready;

	// registers and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_tracked_q <= RST_MIN_TRACKED;
			min_par_q     <= RST_PLX_THR;
			valid_q       <= '0;
			slot_q        <= '0;
			eval_s1       <= 1'b0;
			hit_q         <= 1'b0;
			free_q        <= 1'b0;
			tracked_q     <= '0;
			dropped_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MIN_TRACKED)
					min_tracked_q <= cfg_data[CNT_BITS-1:0];
				else if (cfg_index == CFG_PLX_THR)
					min_par_q <= cfg_data[MINP_BITS-1:0];
			end
			eval_s1 <= cmd.scan;
			if (cmd.slot_clr)
				slot_q <= '0;
			else if (cmd.scan || cmd.next)
				slot_q <= slot_q + SLOT_BITS'(1);
			if (cmd.slot_clr) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (eval_s1) begin
				if (valid_q[slot_s1] && meta_rd_q.ident == id_q && !hit_q)
					hit_q <= 1'b1;
				if (!valid_q[slot_s1] && !free_q)
					free_q <= 1'b1;
			end
			if (cmd.clear) begin
				valid_q   <= '0;
				tracked_q <= '0;
				dropped_q <= 1'b0;
			end else if (cmd.commit) begin
				if (hit_q) begin
					if (hit_meta_q.len < LEN_BITS'(WINDOW)) begin
						if (tracked_q != CNT_SAT)
							tracked_q <= tracked_q + CNT_BITS'(1);
					end else begin
						dropped_q <= 1'b1;
					end
				end else if (free_q) begin
					valid_q[free_slot_q] <= 1'b1;
				end else begin
					dropped_q <= 1'b1;
				end
			end else if (cmd.out_load) begin
				tracked_q <= '0;
				dropped_q <= 1'b0;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action_t'(in_action);
			frame_q <= in_frame;
			id_q    <= in_id;
			pt_q    <= {in_x, in_y};
		end
		slot_s1 <= slot_q;
		if (eval_s1) begin
			if (valid_q[slot_s1] && meta_rd_q.ident == id_q && !hit_q) begin
				hit_slot_q <= slot_s1;
				hit_meta_q <= meta_rd_q;
			end
			if (!valid_q[slot_s1] && !free_q)
				free_slot_q <= slot_s1;
		end
		if (cmd.chk)
			idx_q <= idx_d;
		if (cmd.p0_lat)
			p0_q <= pts_rd_q;
		if (cmd.diff) begin
			dx_q <= ddx[COORD_BITS] ? DIFF_BITS'(-ddx) : DIFF_BITS'(ddx);
			dy_q <= ddy[COORD_BITS] ? DIFF_BITS'(-ddy) : DIFF_BITS'(ddy);
		end
		if (cmd.mul) begin
			rad_q <= RAD_BITS'(dx_q) * RAD_BITS'(dx_q) + RAD_BITS'(dy_q) * RAD_BITS'(dy_q);
			res_q <= '0;
			bit_q <= RAD_BITS'(1) << (2 * (ROOT_BITS - 1));
		end else if (cmd.sqrt_step) begin
			if (rad_q >= trial) begin
				rad_q <= rad_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.dec_init || cmd.direct) begin
			sum_q   <= '0;
			cnt_q   <= '0;
			force_q <= cmd.direct;
		end else if (cmd.acc) begin
			sum_q <= sum_q + SUM_BITS'(res_q);
			cnt_q <= cnt_q + CNT_BITS'(1);
		end
		if (cmd.prod || cmd.direct)
			prod_q <= SUM_BITS'(min_par_q) * SUM_BITS'(cnt_q);
		if (cmd.out_load) begin
			out_key     <= force_q || (cnt_q == '0) || (sum_q >= prod_q);
			out_tracked <= tracked_q;
			out_count   <= cnt_q;
			out_dropped <= dropped_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/feature_track_keyframe_parallax.sv
// Feature-track table with keyframe parallax decision. Up to 256 tracks, each with an id,
// start frame and up to 128 Q4.12 points, held in block memories (track metadata 256 words,
// point history 32768 words); only the per-track valid bits are flip-flops, so reset and a
// clear item empty the table at once with no clearing pass. Words arrive on "feature"; an
// add word (action 0) walks all 256 slots through the metadata memory, one slot a cycle. A
// clear word (action 2) or action 3 gives nothing. An end-of-frame word (action 1) gives one
// word on "decision", decided on frame index or tracked count alone, or else after a walk over
// all 256 slots with, for every qualifying track, two point reads, difference, square and an
// 18-step bit-serial square root. One word is worked on at a time; the next is taken as soon
// as the block is back in idle, even while the previous decision still waits on the output
// register. Configuration (cfg_index 0 min_tracked, 1 parallax threshold) may be written only
// while idle.
module feature_track_keyframe_parallax (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ftkp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [ftkp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	ftkp_item_if.sink                           feature,
	ftkp_res_if.source                          decision
);
	import ftkp_pkg::*;

	ftkp_cmd_t  cmd;
	ftkp_stat_t stat;

	// sequencer: one-hot state machine, issues one command set per cycle
	ftkp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (feature.valid),
		.in_ready (feature.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table memories, slot walk, square root, accumulators and the output register
	ftkp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_action   (feature.action),
		.in_frame    (feature.frame_index),
		.in_id       (feature.feat_tag),
		.in_x        (feature.point_x),
		.in_y        (feature.point_y),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (decision.valid),
		.out_ready   (decision.ready),
		.out_key     (decision.is_keyframe),
		.out_tracked (decision.tracked_count),
		.out_count   (decision.parallax_count),
		.out_dropped (decision.dropped_flag)
	);

endmodule

>>> rtl/ftkp_checker.sv
module ftkp_props (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        out_key,
	input logic [ftkp_pkg::CNT_BITS-1:0] out_count
);
	import ftkp_pkg::*;

	// decision word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("decision word dropped while stalled");

	// every accepted word leaves the block busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("feature word taken back to back");

	// no qualifying track means keyframe
	a_empty_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_count == '0 |-> out_key)
		else $error("empty parallax set without keyframe");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_count <= CNT_BITS'(MAX_TRACKS))
		else $error("parallax count beyond table size");

endmodule

bind feature_track_keyframe_parallax ftkp_props u_ftkp_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (feature.valid),
	.in_ready  (feature.ready),
	.out_valid (decision.valid),
	.out_ready (decision.ready),
	.out_key   (decision.is_keyframe),
	.out_count (decision.parallax_count)
);

>>> test/ftkp_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own copy of the track table and
// checks every decision word against the predicted one, oldest first.
module ftkp_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ftkp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [ftkp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	ftkp_item_if                                feature,
	ftkp_res_if                                 decision,
	output int                                  errors,
	output int                                  outstanding
);
	import ftkp_pkg::*;

	typedef struct {
		logic                key;
		logic [CNT_BITS-1:0] tracked;
		logic [CNT_BITS-1:0] plx_cnt;
		logic                dropped;
	} verdict_t;

	verdict_t verdicts_due[$];

	logic [CNT_BITS-1:0]   thr_tracked;
	logic [MINP_BITS-1:0]  thr_parallax;
	logic                  trk_live  [MAX_TRACKS];
	logic [ID_BITS-1:0]    trk_id    [MAX_TRACKS];
	logic [FRAME_BITS-1:0] trk_first [MAX_TRACKS];
	int                    trk_len   [MAX_TRACKS];
	logic signed [COORD_BITS-1:0] hist_x [MAX_TRACKS][WINDOW];
	logic signed [COORD_BITS-1:0] hist_y [MAX_TRACKS][WINDOW];
	int                    hits_now;
	logic                  drop_now;

	assign outstanding = verdicts_due.size();

	function automatic longint unsigned int_root(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	task automatic wipe_table();
		for (int s = 0; s < MAX_TRACKS; s++)
			trk_live[s] = 1'b0;
		hits_now = 0;
		drop_now = 1'b0;
	endtask

	task automatic place_point(input logic [FRAME_BITS-1:0] fr, input logic [ID_BITS-1:0] id,
			input logic signed [COORD_BITS-1:0] x, input logic signed [COORD_BITS-1:0] y);
		int spare;
		spare = -1;
		for (int s = 0; s < MAX_TRACKS; s++) begin
			if (trk_live[s] && trk_id[s] == id) begin
				if (trk_len[s] >= WINDOW) begin
					drop_now = 1'b1;
				end else begin
					hist_x[s][trk_len[s]] = x;
					hist_y[s][trk_len[s]] = y;
					trk_len[s]++;
					if (hits_now < 511)
						hits_now++;
				end
				return;
			end
			if (!trk_live[s] && spare < 0)
				spare = s;
		end
		if (spare < 0) begin
			drop_now = 1'b1;
			return;
		end
		trk_live[spare]  = 1'b1;
		trk_id[spare]    = id;
		trk_first[spare] = fr;
		trk_len[spare]   = 1;
		hist_x[spare][0] = x;
		hist_y[spare][0] = y;
	endtask

	function automatic verdict_t judge_frame(input logic [FRAME_BITS-1:0] fr);
		verdict_t v;
		longint unsigned acc, dx, dy;
		int cnt, f, st, i;
		acc = 0;
		cnt = 0;
		f = int'(fr);
		v.key = 1'b0;
		if (f < 2 || hits_now < int'(thr_tracked)) begin
			v.key = 1'b1;
		end else begin
			for (int s = 0; s < MAX_TRACKS; s++) begin
				st = int'(trk_first[s]);
				if (!trk_live[s] || st > f - 2 || st + trk_len[s] < f)
					continue;
				i = f - 2 - st;
				dx = longint'(hist_x[s][i]) >= longint'(hist_x[s][i+1]) ?
					longint'(hist_x[s][i]) - longint'(hist_x[s][i+1]) :
					longint'(hist_x[s][i+1]) - longint'(hist_x[s][i]);
				dy = longint'(hist_y[s][i]) >= longint'(hist_y[s][i+1]) ?
					longint'(hist_y[s][i]) - longint'(hist_y[s][i+1]) :
					longint'(hist_y[s][i+1]) - longint'(hist_y[s][i]);
				acc += int_root(dx * dx + dy * dy);
				cnt++;
			end
			if (cnt == 0 || acc >= longint'(thr_parallax) * cnt)
				v.key = 1'b1;
		end
		if (cnt > 511)
			cnt = 511;
		v.tracked = CNT_BITS'(hits_now);
		v.plx_cnt = CNT_BITS'(cnt);
		v.dropped = drop_now;
		return v;
	endfunction

	task automatic report(input string field, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	initial
		errors = 0;

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			thr_tracked  = RST_MIN_TRACKED;
			thr_parallax = RST_PLX_THR;
			wipe_table();
			verdicts_due.delete();
		end else begin
			// the word leaving now always belongs to an earlier decide, so pop first
			if (decision.valid && decision.ready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t decision word with nothing expected", $realtime);
					errors++;
				end else begin
					want = verdicts_due.pop_front();
					if (decision.is_keyframe !== want.key)
						report("is_keyframe", decision.is_keyframe, want.key);
					if (decision.tracked_count !== want.tracked)
						report("tracked_count", decision.tracked_count, want.tracked);
					if (decision.parallax_count !== want.plx_cnt)
						report("parallax_count", decision.parallax_count, want.plx_cnt);
					if (decision.dropped_flag !== want.dropped)
						report("dropped_flag", decision.dropped_flag, want.dropped);
				end
			end
			if (feature.valid && feature.ready) begin
				case (action_t'(feature.action))
					ACT_ADD: place_point(feature.frame_index, feature.feat_tag,
						feature.point_x, feature.point_y);
					ACT_DECIDE: begin
						verdicts_due.insert(verdicts_due.size(),
							judge_frame(feature.frame_index));
						hits_now = 0;
						drop_now = 1'b0;
					end
					ACT_CLEAR: wipe_table();
					default: ;
				endcase
			end
			if (cfg_we) begin
				if (cfg_index == CFG_MIN_TRACKED)
					thr_tracked = cfg_data[CNT_BITS-1:0];
				else if (cfg_index == CFG_PLX_THR)
					thr_parallax = cfg_data[MINP_BITS-1:0];
			end
		end
	end

endmodule

>>> test/tb_feature_track_keyframe_parallax.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the track table; all checking sits in ftkp_checker.
module tb_feature_track_keyframe_parallax;
	import ftkp_pkg::*;

	// an add word walks every slot, so settle for longer than that walk
	localparam int SETTLE     = 300;
	localparam int TAIL       = 600;
	// the longest decide runs a square root for every slot; RX_HOLD is the forced output stall
	localparam int QUIET_MAX  = 50000;
	localparam int RX_HOLD    = 3000;
	localparam int WORDS_GOAL = 800;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int                       errors;
	int                       outstanding;
	int                       words_sent;
	int                       results_seen;
	int                       quiet;
	logic                     tx_calm;
	logic                     rx_calm;
	logic                     rx_held;

	ftkp_item_if feature_bus ();
	ftkp_res_if  decision_bus ();

	feature_track_keyframe_parallax u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.feature  (feature_bus),
		.decision (decision_bus)
	);

	ftkp_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.feature    (feature_bus),
		.decision   (decision_bus),
		.errors     (errors),
		.outstanding(outstanding)
	);

	always #4 clk = ~clk;

	// mostly back to back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 150);
	endfunction

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic push_word(input action_t act, input logic [FRAME_BITS-1:0] fr,
			input logic [ID_BITS-1:0] id, input logic signed [COORD_BITS-1:0] x,
			input logic signed [COORD_BITS-1:0] y);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			feature_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		feature_bus.action      <= act;
		feature_bus.frame_index <= fr;
		feature_bus.feat_tag    <= id;
		feature_bus.point_x     <= x;
		feature_bus.point_y     <= y;
		feature_bus.valid       <= 1'b1;
		@(posedge clk);
		while (!feature_bus.ready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// sender parks until every decision is back, then lets a trailing add finish
	task automatic drain();
		feature_bus.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// A clip: clear, then frames 0..n-1 over a pool of moving features, each frame closed by
	// a decide. Some features miss a frame, some repeat, and junk words are mixed in.
	task automatic run_clip(input int frames, input int pool, input int speed);
		logic [ID_BITS-1:0] ids [16];
		int px [16], py [16], vx [16], vy [16];
		int f, k;
		push_word(ACT_CLEAR, '0, '0, '0, '0);
		for (k = 0; k < pool; k++) begin
			ids[k] = ID_BITS'($urandom);
			px[k]  = $urandom_range(0, 40000) - 20000;
			py[k]  = $urandom_range(0, 40000) - 20000;
			vx[k]  = $urandom_range(0, 2 * speed) - speed;
			vy[k]  = $urandom_range(0, 2 * speed) - speed;
		end
		for (f = 0; f < frames; f++) begin
			for (k = 0; k < pool; k++) begin
				if ($urandom_range(9) < 8)
					push_word(ACT_ADD, FRAME_BITS'(f), ids[k],
						COORD_BITS'(px[k] + vx[k] * f + $urandom_range(0, 64) - 32),
						COORD_BITS'(py[k] + vy[k] * f + $urandom_range(0, 64) - 32));
				// the same id twice in a frame counts as a second hit
				if ($urandom_range(19) == 0)
					push_word(ACT_ADD, FRAME_BITS'(f), ids[k],
						COORD_BITS'($urandom), COORD_BITS'($urandom));
				if ($urandom_range(11) == 0)
					push_word(action_t'($urandom_range(0, 3)), FRAME_BITS'($urandom),
						ID_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom));
			end
			push_word(ACT_DECIDE, FRAME_BITS'(f), '0, '0, '0);
		end
	endtask

	// output side: one long hold-off early on while words keep coming, otherwise random
	initial begin
		int g;
		decision_bus.ready = 1'b0;
		rx_held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!rx_held && results_seen >= 3) begin
				rx_held = 1'b1;
				decision_bus.ready <= 1'b0;
				repeat (RX_HOLD) @(negedge clk);
			end else if (rx_calm) begin
				decision_bus.ready <= 1'b1;
			end else begin
				g = pick_gap();
				if (g == 0) begin
					decision_bus.ready <= 1'b1;
				end else begin
					decision_bus.ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	// watchdog: any stretch with no word moving on either side
	always @(posedge clk) begin
		if ((feature_bus.valid && feature_bus.ready) ||
				(decision_bus.valid && decision_bus.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (decision_bus.valid && decision_bus.ready)
			results_seen <= results_seen + 1;
		if (quiet >= QUIET_MAX) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int k, clip;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		feature_bus.valid = 1'b0;
		feature_bus.action = ACT_NONE;
		feature_bus.frame_index = '0;
		feature_bus.feat_tag = '0;
		feature_bus.point_x = '0;
		feature_bus.point_y = '0;
		words_sent = 0;
		results_seen = 0;
		quiet = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: threshold extremes, coordinate extremes, every action
		write_reg(CFG_MIN_TRACKED, 16'd0);
		write_reg(CFG_PLX_THR, 16'hFFFF);
		push_word(ACT_CLEAR, '0, '0, '0, '0);
		push_word(ACT_ADD, 7'd0, 20'd0, 16'sh8000, 16'sh8000);
		push_word(ACT_ADD, 7'd0, 20'hFFFFF, 16'sh7FFF, 16'sh7FFF);
		push_word(ACT_DECIDE, 7'd0, '0, '0, '0);
		push_word(ACT_ADD, 7'd1, 20'd0, 16'sh7FFF, 16'sh7FFF);
		push_word(ACT_ADD, 7'd1, 20'hFFFFF, 16'sh8000, 16'sh8000);
		push_word(ACT_ADD, 7'd1, 20'd5, 16'sh1000, -16'sh1000);
		push_word(ACT_DECIDE, 7'd1, '0, '0, '0);
		push_word(ACT_ADD, 7'd2, 20'd0, '0, '0);
		push_word(ACT_ADD, 7'd2, 20'hFFFFF, '0, '0);
		push_word(ACT_ADD, 7'd2, 20'd5, 16'sh1000, -16'sh1000);
		push_word(ACT_DECIDE, 7'd2, '0, '0, '0);
		push_word(ACT_NONE, 7'h7F, 20'hFFFFF, 16'sh7FFF, 16'sh7FFF);
		push_word(ACT_ADD, 7'h7F, 20'h12345, -16'sd1, 16'sd1);
		push_word(ACT_DECIDE, 7'd3, '0, '0, '0);
		// a repeated frame with no new adds: count from a stale pair
		push_word(ACT_DECIDE, 7'd2, '0, '0, '0);
		push_word(ACT_CLEAR, 7'd9, 20'hABCDE, '0, '0);
		push_word(ACT_DECIDE, 7'd5, '0, '0, '0);
		drain();

		// full table: more new ids than slots in one frame, then history overflow on one id
		write_reg(CFG_MIN_TRACKED, 16'd256);
		write_reg(CFG_PLX_THR, 16'd0);
		rx_calm = 1'b1;
		tx_calm = 1'b1;
		for (k = 0; k < MAX_TRACKS + 3; k++)
			push_word(ACT_ADD, 7'd4, ID_BITS'(k * 4099 + 7), COORD_BITS'($urandom),
				COORD_BITS'($urandom));
		push_word(ACT_DECIDE, 7'd4, '0, '0, '0);
		push_word(ACT_CLEAR, '0, '0, '0, '0);
		for (k = 0; k < WINDOW + 3; k++)
			push_word(ACT_ADD, 7'd0, 20'h5A5A5, COORD_BITS'($urandom), COORD_BITS'($urandom));
		push_word(ACT_DECIDE, 7'd6, '0, '0, '0);
		drain();

		// random clips, cycling through register settings with the extremes among them
		clip = 0;
		while (words_sent < WORDS_GOAL) begin
			drain();
			case (clip % 5)
				0: begin write_reg(CFG_MIN_TRACKED, 16'd0); write_reg(CFG_PLX_THR, 16'd0); end
				1: begin
					write_reg(CFG_MIN_TRACKED, 16'd256);
					write_reg(CFG_PLX_THR, 16'hFFFF);
				end
				2: begin
					write_reg(CFG_MIN_TRACKED, 16'd2);
					write_reg(CFG_PLX_THR, 16'd4096);
				end
				3: begin
					write_reg(CFG_MIN_TRACKED, 16'd0);
					write_reg(CFG_PLX_THR, 16'hFFFF);
				end
				default: begin
					write_reg(CFG_MIN_TRACKED, 16'($urandom_range(0, 8)));
					write_reg(CFG_PLX_THR, 16'($urandom));
				end
			endcase
			tx_calm = ($urandom_range(3) == 0);
			rx_calm = ($urandom_range(3) == 0);
			run_clip($urandom_range(5, 10), $urandom_range(3, 12),
				(clip % 2) ? 8000 : 2500);
			clip++;
		end

		feature_bus.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
